// ===== src/kjl_pkg.sv =====
// Package for the k-jump ladder way counter.
// Holds default sizes, field widths, the controller state type and the
// command and status bundles shared by the controller and the datapath.
package kjl_pkg;

   // Default sizes for the top-level parameters
   localparam int MAX_STEPS_DEFAULT = 1023;
   localparam int MAX_JUMP_DEFAULT  = 64;

   // Fixed field widths
   localparam int TARGET_W = 10;
   localparam int COUNT_W  = 32;
   localparam int CFG_W    = 7;

   // Reset value of the max_jump register
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd2;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INIT,
      ST_RUN,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;   // capture target and jump limit
      logic init;   // seed the window and the running count
      logic step;   // advance the recurrence by one index
      logic emit;   // move the count into the output register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic zero_steps;   // target is zero
      logic last_step;    // current index equals the target
      logic out_free;     // output register can take a new item
   } status_type;

endpackage

// ===== src/kjl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used as the count window of the way counter.
module kjl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/kjl_ctrl.sv =====
// Controller state machine of the way counter.
// Depends on kjl_pkg for the state, command and status types.
module kjl_ctrl
   import kjl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = status.zero_steps ? ST_FINISH : ST_RUN;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (status.last_step) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold the count until the output register frees up
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/kjl_datapath.sv =====
// Datapath of the way counter: jump register, index and slot counters,
// running count, count window RAM and output register.
// Depends on kjl_pkg and kjl_ram.
module kjl_datapath
   import kjl_pkg::*;
#(
   parameter int MAX_STEPS = MAX_STEPS_DEFAULT,
   parameter int MAX_JUMP  = MAX_JUMP_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_W-1:0]    csr_max_jump,
   input  logic [TARGET_W-1:0] req_target_steps,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COUNT_W-1:0]  rsp_way_count,
   input  cmd_type             cmd,
   output status_type          status
);

   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam int DEPTH  = MAX_JUMP + 1;
   localparam int SLOT_W = $clog2(DEPTH);

   logic [CFG_W-1:0]   cfg_ff;
   logic [STEP_W-1:0]  n_ff, n_in;
   logic [SLOT_W-1:0]  k_ff, k_in;
   logic [STEP_W-1:0]  i_ff, i_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [COUNT_W-1:0] prev_ff, prev_in;
   logic [COUNT_W-1:0] next_count;
   logic [COUNT_W-1:0] doubled;
   logic [COUNT_W-1:0] win_rd_data;
   logic               win_wr_en;
   logic [SLOT_W-1:0]  win_wr_addr;
   logic [COUNT_W-1:0] win_wr_data;
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_data_ff;

   // Configuration register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         cfg_ff <= csr_max_jump;
      end
   end

   // Clamp target and jump limit at load
   always_comb begin
      if (32'(req_target_steps) > 32'(MAX_STEPS)) begin
         n_in = STEP_W'(MAX_STEPS);
      end else begin
         n_in = STEP_W'(req_target_steps);
      end
      if (cfg_ff == '0) begin
         k_in = SLOT_W'(1);
      end else if (32'(cfg_ff) > 32'(MAX_JUMP)) begin
         k_in = SLOT_W'(MAX_JUMP);
      end else begin
         k_in = SLOT_W'(cfg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff <= n_in;
         k_ff <= k_in;
      end
   end

   // One recurrence step: rd data is the count from k+1 indices back
   assign doubled = {prev_ff[COUNT_W-2:0], 1'b0};

   always_comb begin
      if (i_ff == STEP_W'(1)) begin
         next_count = COUNT_W'(1);
      end else if (32'(i_ff) <= 32'(k_ff)) begin
         next_count = doubled;
      end else begin
         next_count = doubled - win_rd_data;
      end
   end

   // Advance index, slot and running count
   always_comb begin
      i_in    = i_ff;
      slot_in = slot_ff;
      prev_in = prev_ff;
      if (cmd.init) begin
         i_in    = STEP_W'(1);
         slot_in = SLOT_W'(1);
         prev_in = COUNT_W'(1);
      end else if (cmd.step) begin
         i_in    = i_ff + STEP_W'(1);
         slot_in = (slot_ff == k_ff) ? '0 : slot_ff + SLOT_W'(1);
         prev_in = next_count;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      slot_ff <= slot_in;
      prev_ff <= prev_in;
   end

   // Window writes: seed slot zero, then one count per step
   assign win_wr_en   = cmd.init | cmd.step;
   assign win_wr_addr = cmd.init ? '0 : slot_ff;
   assign win_wr_data = cmd.init ? COUNT_W'(1) : next_count;

   // Read ahead the slot the next step will overwrite
   kjl_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (win_wr_en),
      .wr_addr (win_wr_addr),
      .wr_data (win_wr_data),
      .rd_addr (slot_in),
      .rd_data (win_rd_data)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= prev_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_way_count = rsp_data_ff;

   // Status back to the controller
   assign status.zero_steps = (n_ff == '0);
   assign status.last_step  = (i_ff == n_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   // A pending result is never overwritten
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result emitted over a pending one");

   // An emitted result shows up on the next cycle
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted result not valid");

   // The index never runs past the target
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (i_ff <= n_ff && i_ff != '0))
      else $error("step index out of range");

endmodule

// ===== src/k_jump_ladder_way_counter.sv =====
// k-jump ladder way counter: counts jump sequences of 1..k steps that
// climb n steps, modulo 2^32. Top level; depends on kjl_pkg, kjl_ctrl,
// kjl_datapath and kjl_ram.
//
// Usage:
//   csr_*  : write max_jump (k) while the block is idle; always ready.
//            Zero counts as 1, values above MAX_JUMP saturate.
//   req_*  : one target step count n per item; n above MAX_STEPS saturates.
//            req_ready is high only while the counter is idle.
//   rsp_*  : one way count per item, held in an output register.
// Timing: after the accepting edge, a set-up state, then one recurrence
//   step per cycle through the count window RAM (one write and one
//   read-ahead per cycle), then a finish state that loads the output
//   register once it is free. The block takes no new item until the
//   current one has left the finish state; n = 0 skips the steps.
// Stall: the next item is accepted while a result waits on rsp_ready; its
//   finished count then holds until the output register frees up.
// Reset: synchronous, clears the controller, the output valid and sets
//   max_jump to 2. The window RAM needs no clearing: every entry is
//   written within an item before its read data is used.
module k_jump_ladder_way_counter
   import kjl_pkg::*;
#(
   parameter int MAX_STEPS = MAX_STEPS_DEFAULT,
   parameter int MAX_JUMP  = MAX_JUMP_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_W-1:0]    csr_max_jump,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [TARGET_W-1:0] req_target_steps,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COUNT_W-1:0]  rsp_way_count
);

   cmd_type    cmd;
   status_type status;

   kjl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kjl_datapath #(
      .MAX_STEPS (MAX_STEPS),
      .MAX_JUMP  (MAX_JUMP)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_jump     (csr_max_jump),
      .req_target_steps (req_target_steps),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_way_count    (rsp_way_count),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
